[rtl/gamepad_output_report_framer_assert.svh]
// Assertion macros for the gamepad output report framer.
`ifndef GAMEPAD_OUTPUT_REPORT_FRAMER_ASSERT_SVH
`define GAMEPAD_OUTPUT_REPORT_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define GORF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gorf: property violated");
`define GORF_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("gorf: forbidden condition seen");
`else
`define GORF_ASSERT(lbl, prop)
`define GORF_NEVER(lbl, expr)
`endif
`endif

[rtl/gorf_pkg.sv]
// Types, constants and CRC helpers for the gamepad output report framer.
`timescale 1ns / 1ps

package gorf_pkg;

    // Register indexes (paddr[2])
    localparam logic REG_LINK_WIRED = 1'b0;
    localparam logic REG_PAD_FORMAT = 1'b1;

    // Report lengths in bytes and last word index per layout
    localparam logic [6:0] LEN_OLD_WIRED = 7'd31;
    localparam logic [6:0] LEN_NEW_WIRED = 7'd74;
    localparam logic [6:0] LEN_WIRELESS  = 7'd78;
    localparam logic [4:0] LAST_OLD_WIRED = 5'd7;
    localparam logic [4:0] LAST_NEW_WIRED = 5'd18;
    localparam logic [4:0] LAST_WIRELESS  = 5'd19;

    // Wireless words 0..17 are pure data, 18 holds the CRC low half, 19 the high half
    localparam logic [4:0] CRC_DATA_WORDS = 5'd18;
    localparam logic [4:0] WORD_CRC_LO    = 5'd18;
    localparam logic [4:0] WORD_CRC_HI    = 5'd19;

    // Fixed report bytes
    localparam logic [7:0] BYTE_FF        = 8'hFF;
    localparam logic [7:0] ID_OLD_WIRED   = 8'h05;
    localparam logic [7:0] ID_OLD_WLESS   = 8'h11;
    localparam logic [7:0] OLD_WLESS_B2   = 8'hC0;
    localparam logic [7:0] OLD_WLESS_B3   = 8'h20;
    localparam logic [7:0] OLD_WLESS_B4   = 8'h07;
    localparam logic [7:0] ID_NEW_WIRED   = 8'h02;
    localparam logic [7:0] ID_NEW_WLESS   = 8'h31;
    localparam logic [7:0] NEW_FLAG_02    = 8'h02;
    localparam logic [7:0] NEW_FLAG_03    = 8'h03;
    localparam logic [7:0] NEW_FLAG_54    = 8'h54;
    localparam logic [7:0] PL_MASK        = 8'h7F;

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_SEED   = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;
    localparam logic [7:0]  CRC_HDR    = 8'hA2;

    typedef logic [3:0][255:0][31:0] crc_tabs_t;

    // Packed MSB first, so small_rumble lands in bits 7:0
    typedef struct packed {
        logic [7:0] player_lights;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] big_rumble;
        logic [7:0] small_rumble;
    } item_t;

    // Per-word control carried down the pipeline
    typedef struct packed {
        logic [2:0] valid_bytes;
        logic       last;
        logic       crc_lo;
        logic       crc_hi;
    } word_ctl_t;

    // Slicing-by-4 tables, built at elaboration
    function automatic crc_tabs_t crc_tab_gen();
        crc_tabs_t   t;
        logic [31:0] c;
        for (int n = 0; n < 256; n++)
        begin
            c = 32'(n);
            for (int b = 0; b < 8; b++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            t[0][n] = c;
        end
        for (int s = 1; s < 4; s++)
        begin
            for (int n = 0; n < 256; n++)
            begin
                t[s][n] = (t[s-1][n] >> 8) ^ t[0][t[s-1][n][7:0]];
            end
        end
        return t;
    endfunction

    // CRC state after the header byte
    function automatic logic [31:0] crc_init_gen();
        logic [31:0] c;
        c = CRC_SEED ^ {24'h0, CRC_HDR};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    localparam crc_tabs_t   CRC_TABS = crc_tab_gen();
    localparam logic [31:0] CRC_INIT = crc_init_gen();

    // Four bytes, low byte first
    function automatic logic [31:0] crc_step4(logic [31:0] c, logic [31:0] w);
        logic [31:0] x;
        x = c ^ w;
        return CRC_TABS[3][x[7:0]] ^ CRC_TABS[2][x[15:8]] ^
               CRC_TABS[1][x[23:16]] ^ CRC_TABS[0][x[31:24]];
    endfunction

    // Two bytes, low byte first
    function automatic logic [31:0] crc_step2(logic [31:0] c, logic [15:0] h);
        logic [15:0] x;
        x = c[15:0] ^ h;
        return (c >> 16) ^ CRC_TABS[1][x[7:0]] ^ CRC_TABS[0][x[15:8]];
    endfunction

    // Frame byte at position p for the selected layout (CRC bytes read as zero)
    function automatic logic [7:0] report_byte(logic wired, logic fmt, item_t it,
                                               logic [6:0] p);
        logic [7:0] v;
        logic [7:0] pl;
        v  = 8'h00;
        pl = it.player_lights & PL_MASK;
        unique case ({wired, fmt})
            2'b10:
            begin
                case (p)
                    7'd0:    v = ID_OLD_WIRED;
                    7'd1:    v = BYTE_FF;
                    7'd4:    v = it.small_rumble;
                    7'd5:    v = it.big_rumble;
                    7'd6:    v = it.red;
                    7'd7:    v = it.green;
                    7'd8:    v = it.blue;
                    7'd9:    v = BYTE_FF;
                    default: v = 8'h00;
                endcase
            end
            2'b00:
            begin
                case (p)
                    7'd1:    v = ID_OLD_WLESS;
                    7'd2:    v = OLD_WLESS_B2;
                    7'd3:    v = OLD_WLESS_B3;
                    7'd4:    v = OLD_WLESS_B4;
                    7'd7:    v = it.small_rumble;
                    7'd8:    v = it.big_rumble;
                    7'd9:    v = it.red;
                    7'd10:   v = it.green;
                    7'd11:   v = it.blue;
                    7'd12:   v = BYTE_FF;
                    default: v = 8'h00;
                endcase
            end
            2'b11:
            begin
                case (p)
                    7'd1:    v = ID_NEW_WIRED;
                    7'd2:    v = NEW_FLAG_03;
                    7'd3:    v = NEW_FLAG_54;
                    7'd4:    v = it.small_rumble;
                    7'd5:    v = it.big_rumble;
                    7'd40:   v = NEW_FLAG_02;
                    7'd41:   v = NEW_FLAG_02;
                    7'd44:   v = NEW_FLAG_02;
                    7'd45:   v = pl;
                    7'd46:   v = it.red;
                    7'd47:   v = it.green;
                    7'd48:   v = it.blue;
                    default: v = 8'h00;
                endcase
            end
            default:
            begin
                case (p)
                    7'd1:    v = ID_NEW_WLESS;
                    7'd2:    v = NEW_FLAG_02;
                    7'd3:    v = NEW_FLAG_03;
                    7'd4:    v = NEW_FLAG_54;
                    7'd5:    v = it.small_rumble;
                    7'd6:    v = it.big_rumble;
                    7'd41:   v = NEW_FLAG_02;
                    7'd44:   v = NEW_FLAG_02;
                    7'd45:   v = NEW_FLAG_02;
                    7'd46:   v = pl;
                    7'd47:   v = it.red;
                    7'd48:   v = it.green;
                    7'd49:   v = it.blue;
                    default: v = 8'h00;
                endcase
            end
        endcase
        return v;
    endfunction

endpackage

[rtl/gamepad_output_report_framer.sv]
// Gamepad output report framer: builds wired or wireless reports, appends CRC-32.
//
//   channel  dir  handshake            carries
//   s_*      in   tvalid/tready        one request: rumble, color, player lights
//   m_*      out  tvalid/tready/tlast  one report word, byte count, last flag
//   apb      in   psel/penable/pready  link_wired at 0x0, pad_format at 0x4
//
// One word leaves per cycle unless m_tready stalls; an item is 8 (older wired),
// 19 (newer wired) or 20 (wireless) words, walked by the word sequencer, which
// runs the CRC four bytes a cycle while it emits. The item is registered, then
// each word passes the stage 1, stage 2 and output registers. The next item is
// taken as the sequencer hands off its last word. A stall on m_tready holds every
// stage; words move only into free or draining stages. rst_n clears control
// and the registers (wireless, older format).
`timescale 1ns / 1ps
`include "gamepad_output_report_framer_assert.svh"

module gamepad_output_report_framer (
    input  logic        clk,
    input  logic        rst_n,
    // request item
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] small_rumble, [15:8] big_rumble, [23:16] red, [31:24] green,
    // [39:32] blue, [47:40] player_lights
    input  logic [47:0] s_tdata,
    // report words
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] report_word, [34:32] valid_bytes, [39:35] zero
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic link_wired_reg;
    logic pad_format_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_wired_reg <= 1'b0;
            pad_format_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                gorf_pkg::REG_LINK_WIRED: link_wired_reg <= pwdata[0];
                gorf_pkg::REG_PAD_FORMAT: pad_format_reg <= pwdata[0];
                default:                  link_wired_reg <= link_wired_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            gorf_pkg::REG_LINK_WIRED: prdata = {31'h0, link_wired_reg};
            gorf_pkg::REG_PAD_FORMAT: prdata = {31'h0, pad_format_reg};
            default:                  prdata = 32'h0;
        endcase
    end

    // ---------------- stage handshakes ----------------
    logic s1_v_reg, s2_v_reg, out_v_reg;
    logic out_ready, s2_ready, s1_ready;
    logic busy_reg;
    logic emit;
    logic accept;

    assign out_ready = !out_v_reg || m_tready;
    assign s2_ready  = !s2_v_reg || out_ready;
    assign s1_ready  = !s1_v_reg || s2_ready;

    // ---------------- stage 0: word sequencer and running CRC ----------------
    gorf_pkg::item_t item_reg;
    logic [4:0]      k_reg;
    logic [31:0]     crc_reg;
    logic [4:0]      last_k;
    logic [6:0]      rpt_len;
    logic            start_off;
    logic [6:0]      rem_bytes;
    logic [2:0]      word_cnt;
    logic [31:0]     word_raw;
    gorf_pkg::word_ctl_t word_ctl;
    logic [6:0]      pos;

    always_comb
    begin
        if (link_wired_reg)
        begin
            last_k  = pad_format_reg ? gorf_pkg::LAST_NEW_WIRED : gorf_pkg::LAST_OLD_WIRED;
            rpt_len = pad_format_reg ? gorf_pkg::LEN_NEW_WIRED : gorf_pkg::LEN_OLD_WIRED;
        end
        else
        begin
            last_k  = gorf_pkg::LAST_WIRELESS;
            rpt_len = gorf_pkg::LEN_WIRELESS;
        end
    end

    // Older wired sends the frame from byte 0, every other layout from byte 1
    assign start_off = !(link_wired_reg && !pad_format_reg);
    assign rem_bytes = rpt_len - {k_reg, 2'b00};
    assign word_cnt  = (rem_bytes > 7'd4) ? 3'd4 : rem_bytes[2:0];

    // Gather the word's frame bytes, zero past the byte count
    always_comb
    begin
        word_raw = 32'h0;
        pos      = 7'd0;
        for (int j = 0; j < 4; j++)
        begin
            pos = {k_reg, 2'b00} + 7'(j) + {6'h0, start_off};
            if (3'(j) < word_cnt)
            begin
                word_raw[8*j +: 8] = gorf_pkg::report_byte(link_wired_reg, pad_format_reg,
                                                           item_reg, pos);
            end
        end
    end

    always_comb
    begin
        word_ctl.valid_bytes = word_cnt;
        word_ctl.last        = (k_reg == last_k);
        word_ctl.crc_lo      = !link_wired_reg && (k_reg == gorf_pkg::WORD_CRC_LO);
        word_ctl.crc_hi      = !link_wired_reg && (k_reg == gorf_pkg::WORD_CRC_HI);
    end

    assign emit     = busy_reg && s1_ready;
    assign s_tready = !busy_reg || (emit && word_ctl.last);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= 5'd0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            k_reg    <= 5'd0;
        end
        else if (emit)
        begin
            if (word_ctl.last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                k_reg <= k_reg + 5'd1;
            end
        end
    end

    // Item payload and CRC over data words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= s_tdata;
            crc_reg  <= gorf_pkg::CRC_INIT;
        end
        else if (emit && (k_reg < gorf_pkg::CRC_DATA_WORDS))
        begin
            crc_reg <= gorf_pkg::crc_step4(crc_reg, word_raw);
        end
    end

    // ---------------- stage 1: word register ----------------
    logic [31:0]         s1_word_reg;
    logic [31:0]         s1_crc_reg;
    gorf_pkg::word_ctl_t s1_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_v_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && emit)
        begin
            s1_word_reg <= word_raw;
            s1_crc_reg  <= crc_reg;
            s1_ctl_reg  <= word_ctl;
        end
    end

    // ---------------- stage 2: CRC tail and final xor ----------------
    logic [31:0]         s2_word_reg;
    logic [31:0]         s2_crc_reg;
    gorf_pkg::word_ctl_t s2_ctl_reg;
    logic [31:0]         crc_fin;

    // Last two CRC bytes are the low half of the CRC low-half word
    assign crc_fin = gorf_pkg::crc_step2(s1_crc_reg, s1_word_reg[15:0]) ^
                     gorf_pkg::CRC_XOROUT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_v_reg)
        begin
            s2_word_reg <= s1_word_reg;
            s2_crc_reg  <= crc_fin;
            s2_ctl_reg  <= s1_ctl_reg;
        end
    end

    // ---------------- stage 3: CRC insertion and output register ----------------
    logic [31:0] out_word_next;
    logic [31:0] out_word_reg;
    logic [2:0]  out_cnt_reg;
    logic        out_last_reg;

    always_comb
    begin
        out_word_next = s2_word_reg;
        if (s2_ctl_reg.crc_lo)
        begin
            out_word_next = {s2_crc_reg[15:0], s2_word_reg[15:0]};
        end
        else if (s2_ctl_reg.crc_hi)
        begin
            out_word_next = {16'h0, s2_crc_reg[31:16]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_v_reg)
        begin
            out_word_reg <= out_word_next;
            out_cnt_reg  <= s2_ctl_reg.valid_bytes;
            out_last_reg <= s2_ctl_reg.last;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'h0, out_cnt_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    // A new item never cuts into a report still being walked
    `GORF_ASSERT(a_accept_at_end, accept |-> !busy_reg || (emit && k_reg == last_k))
    // The sequencer never runs past the report's last word
    `GORF_NEVER(a_k_in_range, busy_reg && (k_reg > last_k))
    // Every word before the last one is full
    `GORF_ASSERT(a_full_words, m_tvalid && !m_tlast |-> m_tdata[34:32] == 3'd4)
    // The CRC high half is always the closing word
    `GORF_ASSERT(a_crc_hi_last, s1_v_reg && s1_ctl_reg.crc_hi |-> s1_ctl_reg.last)

endmodule
